>>> rtl/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// shared widths, register codes and the divider stage record for the
// ray / triangle intersection core
// ----------------------------------------------------------------------------
package rti_pkg;

  // coordinate width actually used out of each 21-bit field
  localparam int COORD_BITS = 21;
  localparam int IN_W       = 21;
  localparam int CW         = COORD_BITS;
  localparam int EW         = CW + 1;          // edge / offset vectors
  localparam int RW         = CW + EW + 1;     // r = d x e2
  localparam int QW         = 2 * EW + 1;      // q = p x e1
  localparam int PW         = QW + EW;         // one dot-product term
  localparam int SW         = QW + EW + 3;     // dot sums and beta + gamma

  localparam int REG_W      = 63;
  localparam int EPS_DET_W  = 63;
  localparam int EPS_T_W    = 32;
  localparam int IDX_W      = 3;

  localparam int QB         = 32;              // quotient bits (Q16.16)
  localparam int FRAC       = 16;
  localparam int DENW       = SW - 1;          // positive determinant
  localparam int REMW       = SW;              // partial remainder < 2 * den
  localparam int UW         = (SW > EPS_DET_W) ? SW : EPS_DET_W;
  localparam int SATW       = SW + FRAC;

  localparam logic [IDX_W-1:0] REG_VERTEX_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_VERTEX_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_VERTEX_C = 3'd2;
  localparam logic [IDX_W-1:0] REG_EPS_DET  = 3'd3;
  localparam logic [IDX_W-1:0] REG_EPS_T    = 3'd4;

  // one step of the restoring divider
  typedef struct packed {
    logic            pass;
    logic            sat;
    logic [DENW-1:0] den;
    logic [REMW-1:0] rem;
    logic [QB-1:0]   mix;   // numerator bits still to shift in, quotient shifts in
  } div_t;

  function automatic logic signed [CW-1:0] coord_of(input logic [REG_W-1:0] v,
                                                    input int k);
    return v[k*CW +: CW];
  endfunction

endpackage
`default_nettype wire

>>> rtl/ray_triangle_intersect_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// front-face ray / triangle hit test in fixed point with a pipelined
// Q16.16 distance divide
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  in       | in_valid / in_stall          | origin_x/y/z, dir_x/y/z (Q8.12)
//  out      | out_valid / out_stall        | hit, distance (Q16.16)
//  cfg      | cfg_we (write only)          | cfg_index, cfg_data
//
//  the pipe has 7 geometry stages, 32 divider stages and 1 output stage
//  one ray is taken every cycle unless the pipe is held; the 32-step divider sets the depth
//  the whole pipe advances together; it holds only while the output
//  register is full and stalled, so in_stall = out_valid & out_stall
//  synchronous reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rti_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [rti_pkg::REG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic signed [rti_pkg::IN_W-1:0] origin_x,
  input  wire logic signed [rti_pkg::IN_W-1:0] origin_y,
  input  wire logic signed [rti_pkg::IN_W-1:0] origin_z,
  input  wire logic signed [rti_pkg::IN_W-1:0] dir_x,
  input  wire logic signed [rti_pkg::IN_W-1:0] dir_y,
  input  wire logic signed [rti_pkg::IN_W-1:0] dir_z,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           hit,
  output      logic [rti_pkg::QB-1:0]         distance
);

  // configuration registers
  logic [rti_pkg::REG_W-1:0]     vertex_a, vertex_b, vertex_c;
  logic [rti_pkg::EPS_DET_W-1:0] eps_det;
  logic [rti_pkg::EPS_T_W-1:0]   eps_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
      eps_det  <= rti_pkg::EPS_DET_W'(1);
      eps_t    <= rti_pkg::EPS_T_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_VERTEX_A: vertex_a <= cfg_data;
        rti_pkg::REG_VERTEX_B: vertex_b <= cfg_data;
        rti_pkg::REG_VERTEX_C: vertex_c <= cfg_data;
        rti_pkg::REG_EPS_DET:  eps_det  <= cfg_data;
        rti_pkg::REG_EPS_T:    eps_t    <= cfg_data[rti_pkg::EPS_T_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: the pipe moves unless the output transfer is held
  logic adv;
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  logic [6:0] vld;  // valid bits of geometry stages 1..7

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // input coordinates: the low CW bits of each port, taken as signed
  logic signed [rti_pkg::CW-1:0] o_c [3];
  logic signed [rti_pkg::CW-1:0] d_c [3];

  assign o_c[0] = origin_x[rti_pkg::CW-1:0];
  assign o_c[1] = origin_y[rti_pkg::CW-1:0];
  assign o_c[2] = origin_z[rti_pkg::CW-1:0];
  assign d_c[0] = dir_x[rti_pkg::CW-1:0];
  assign d_c[1] = dir_y[rti_pkg::CW-1:0];
  assign d_c[2] = dir_z[rti_pkg::CW-1:0];

  // stage 1: edges e1 = b - a, e2 = c - a and offset p = o - a
  logic signed [rti_pkg::EW-1:0] e1_1 [3], e2_1 [3], p_1 [3];
  logic signed [rti_pkg::CW-1:0] d_1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_1[k] <= rti_pkg::EW'(rti_pkg::coord_of(vertex_b, k))
                 - rti_pkg::EW'(rti_pkg::coord_of(vertex_a, k));
        e2_1[k] <= rti_pkg::EW'(rti_pkg::coord_of(vertex_c, k))
                 - rti_pkg::EW'(rti_pkg::coord_of(vertex_a, k));
        p_1[k]  <= rti_pkg::EW'(o_c[k])
                 - rti_pkg::EW'(rti_pkg::coord_of(vertex_a, k));
        d_1[k]  <= d_c[k];
      end
    end
  end

  // stage 2: cross-product terms of r = d x e2 and q = p x e1
  logic signed [rti_pkg::CW+rti_pkg::EW-1:0] rm_2 [6];
  logic signed [2*rti_pkg::EW-1:0]           qm_2 [6];
  logic signed [rti_pkg::EW-1:0]             e1_2 [3], e2_2 [3], p_2 [3];
  logic signed [rti_pkg::CW-1:0]             d_2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      rm_2[0] <= d_1[1] * e2_1[2];
      rm_2[1] <= d_1[2] * e2_1[1];
      rm_2[2] <= d_1[2] * e2_1[0];
      rm_2[3] <= d_1[0] * e2_1[2];
      rm_2[4] <= d_1[0] * e2_1[1];
      rm_2[5] <= d_1[1] * e2_1[0];
      qm_2[0] <= p_1[1] * e1_1[2];
      qm_2[1] <= p_1[2] * e1_1[1];
      qm_2[2] <= p_1[2] * e1_1[0];
      qm_2[3] <= p_1[0] * e1_1[2];
      qm_2[4] <= p_1[0] * e1_1[1];
      qm_2[5] <= p_1[1] * e1_1[0];
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      p_2  <= p_1;
      d_2  <= d_1;
    end
  end

  // stage 3: finish the cross products
  logic signed [rti_pkg::RW-1:0] r_3 [3];
  logic signed [rti_pkg::QW-1:0] q_3 [3];
  logic signed [rti_pkg::EW-1:0] e1_3 [3], e2_3 [3], p_3 [3];
  logic signed [rti_pkg::CW-1:0] d_3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        r_3[k] <= rti_pkg::RW'(rm_2[2*k]) - rti_pkg::RW'(rm_2[2*k+1]);
        q_3[k] <= rti_pkg::QW'(qm_2[2*k]) - rti_pkg::QW'(qm_2[2*k+1]);
      end
      e1_3 <= e1_2;
      e2_3 <= e2_2;
      p_3  <= p_2;
      d_3  <= d_2;
    end
  end

  // stage 4: dot-product terms
  logic signed [rti_pkg::PW-1:0] det_m [3], tn_m [3], bn_m [3], gn_m [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        det_m[k] <= r_3[k] * e1_3[k];
        bn_m[k]  <= r_3[k] * p_3[k];
        tn_m[k]  <= q_3[k] * e2_3[k];
        gn_m[k]  <= q_3[k] * d_3[k];
      end
    end
  end

  // stage 5: triple products det, t, beta and gamma numerators
  logic signed [rti_pkg::SW-1:0] det_5, tn_5, bn_5, gn_5;

  always_ff @(posedge clk) begin
    if (adv) begin
      det_5 <= rti_pkg::SW'(det_m[0]) + rti_pkg::SW'(det_m[1]) + rti_pkg::SW'(det_m[2]);
      tn_5  <= rti_pkg::SW'(tn_m[0]) + rti_pkg::SW'(tn_m[1]) + rti_pkg::SW'(tn_m[2]);
      bn_5  <= rti_pkg::SW'(bn_m[0]) + rti_pkg::SW'(bn_m[1]) + rti_pkg::SW'(bn_m[2]);
      gn_5  <= rti_pkg::SW'(gn_m[0]) + rti_pkg::SW'(gn_m[1]) + rti_pkg::SW'(gn_m[2]);
    end
  end

  // stage 6: determinant, t and single barycentric checks
  logic signed [rti_pkg::SW-1:0] det_6, tn_6, bg_6;
  logic                          ok_6;
  logic                          det_pos, det_eps, tn_pos, b_ok, g_ok;

  assign det_pos = (det_5 > 0);
  assign det_eps = rti_pkg::UW'(det_5[rti_pkg::SW-2:0]) >= rti_pkg::UW'(eps_det);
  assign tn_pos  = (tn_5 > 0);
  assign b_ok    = !bn_5[rti_pkg::SW-1] && (bn_5 <= det_5);
  assign g_ok    = !gn_5[rti_pkg::SW-1] && (gn_5 <= det_5);

  always_ff @(posedge clk) begin
    if (adv) begin
      det_6 <= det_5;
      tn_6  <= tn_5;
      bg_6  <= bn_5 + gn_5;
      ok_6  <= det_pos && det_eps && tn_pos && b_ok && g_ok;
    end
  end

  // stage 7: alpha check, saturation and divider setup
  rti_pkg::div_t             div_q [rti_pkg::QB+1];
  logic [rti_pkg::QB:0]      div_vld;
  logic [rti_pkg::SATW-1:0]  tn_wide, det_wide;

  assign tn_wide  = rti_pkg::SATW'(tn_6[rti_pkg::SW-2:0]);
  assign det_wide = rti_pkg::SATW'({det_6[rti_pkg::SW-2:0], {rti_pkg::FRAC{1'b0}}});
  assign div_vld[0] = vld[6];

  always_ff @(posedge clk) begin
    if (adv) begin
      div_q[0].pass <= ok_6 && !bg_6[rti_pkg::SW-1] && (bg_6 <= det_6);
      div_q[0].sat  <= tn_wide >= det_wide;
      div_q[0].den  <= det_6[rti_pkg::SW-2:0];
      // t * 2^16 split: top part seeds the remainder, low part feeds the steps
      div_q[0].rem  <= rti_pkg::REMW'(tn_6[rti_pkg::SW-2:rti_pkg::FRAC]);
      div_q[0].mix  <= {tn_6[rti_pkg::FRAC-1:0], {(rti_pkg::QB-rti_pkg::FRAC){1'b0}}};
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < rti_pkg::QB; i++) begin : g_div
    rti_div_stage u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .d_valid (div_vld[i]),
      .d       (div_q[i]),
      .q_valid (div_vld[i+1]),
      .q       (div_q[i+1])
    );
  end

  // output stage: distance threshold on the quantized t
  rti_pkg::div_t        fin;
  logic                 good;

  assign fin  = div_q[rti_pkg::QB];
  assign good = fin.pass && (fin.sat || (fin.mix > eps_t));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_vld[rti_pkg::QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit      <= good;
      distance <= (good && !fin.sat) ? fin.mix : '1;
    end
  end

  // a miss always reports the saturated distance
  a_miss_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '1)
    else $error("miss with finite distance");

  // held output freezes the geometry stages
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while held");

  // remainder stays below the divisor after the last step
  a_rem: assert property (@(posedge clk) disable iff (rst)
    div_vld[rti_pkg::QB] && fin.pass && !fin.sat |-> fin.rem < rti_pkg::REMW'(fin.den))
    else $error("divider remainder out of range");

endmodule
`default_nettype wire

>>> rtl/rti_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div_stage
// one registered quotient bit of the pipelined restoring divider
// ----------------------------------------------------------------------------
module rti_div_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          d_valid,
  input  wire rti_pkg::div_t d,
  output      logic          q_valid,
  output      rti_pkg::div_t q
);

  logic [rti_pkg::REMW-1:0] trial;
  logic                     ge;

  // shift the next numerator bit into the remainder and try the subtract
  assign trial = {d.rem[rti_pkg::REMW-2:0], d.mix[rti_pkg::QB-1]};
  assign ge    = trial >= rti_pkg::REMW'(d.den);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.pass <= d.pass;
      q.sat  <= d.sat;
      q.den  <= d.den;
      q.rem  <= ge ? (trial - rti_pkg::REMW'(d.den)) : trial;
      q.mix  <= {d.mix[rti_pkg::QB-2:0], ge};
    end
  end

endmodule
`default_nettype wire
